// File: rtl/swm_pkg.sv
// shared types and constants of the swerve module set-point block
package swm_pkg;

	// configuration register indexes
	localparam logic [3:0] CFG_MAX_SPEED        = 4'd0;
	localparam logic [3:0] CFG_SPEED_SCALE      = 4'd1;
	localparam logic [3:0] CFG_REV_PER_METER    = 4'd2;
	localparam logic [3:0] CFG_TICKS_PER_DEGREE = 4'd3;

	// register reset values
	localparam logic [12:0] MAX_SPEED_RST        = 13'd1000;
	localparam logic [8:0]  SPEED_SCALE_RST      = 9'd64;
	localparam logic [21:0] REV_PER_METER_RST    = 22'd205324;
	localparam logic [15:0] TICKS_PER_DEGREE_RST = 16'd18657;

	// angles in centidegrees
	localparam int HALF_TURN  = 18000;
	localparam int FULL_TURN  = 36000;
	localparam int FLIP_LIMIT = 9010;
	localparam int MOVE_LIMIT = 100;

	// drive path constants
	localparam logic [17:0] DEADBAND_MUL = 18'd20;
	localparam logic [16:0] DRIVE_MAX    = 17'd131071;
	localparam logic [45:0] DRIVE_HALF   = 46'd8388608;

	// turn path constants: divide by 25600 as a shift by 10 and a divide by 25
	localparam logic [31:0] TURN_HALF = 32'd12800;
	localparam logic [44:0] RECIP_25  = 45'd5368710;

	// configuration register set
	typedef struct packed {
		logic [12:0] max_speed;
		logic [8:0]  speed_scale;
		logic [21:0] rev_per_meter;
		logic [15:0] ticks_per_degree;
	} cfg_t;

	// angle stage result handed to the drive and turn paths
	typedef struct packed {
		logic [13:0] smag;
		logic        sneg;
		logic        dead;
		logic [14:0] rmag;
		logic        rneg;
		logic        pos;
		logic        flip;
		logic [31:0] ticks;
	} front_t;

endpackage

// File: rtl/swm_cfg.sv
// configuration registers of the swerve module set-point block
module swm_cfg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic [3:0]         wr_index,
	input  logic [21:0]        wr_data,
	output swm_pkg::cfg_t      cfg
);

	swm_pkg::cfg_t cfg_q;

	// register writes, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_speed        <= swm_pkg::MAX_SPEED_RST;
			cfg_q.speed_scale      <= swm_pkg::SPEED_SCALE_RST;
			cfg_q.rev_per_meter    <= swm_pkg::REV_PER_METER_RST;
			cfg_q.ticks_per_degree <= swm_pkg::TICKS_PER_DEGREE_RST;
		end else if (wr_en) begin
			case (wr_index)
				swm_pkg::CFG_MAX_SPEED:        cfg_q.max_speed        <= wr_data[12:0];
				swm_pkg::CFG_SPEED_SCALE:      cfg_q.speed_scale      <= wr_data[8:0];
				swm_pkg::CFG_REV_PER_METER:    cfg_q.rev_per_meter    <= wr_data;
				swm_pkg::CFG_TICKS_PER_DEGREE: cfg_q.ticks_per_degree <= wr_data[15:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: rtl/swm_angle.sv
// first stage: angle error wrap, flip decision and speed deadband
module swm_angle (
	input  logic                clk,
	input  logic                en,
	input  logic signed [13:0]  target_speed,
	input  logic signed [15:0]  target_angle,
	input  logic signed [15:0]  current_angle,
	input  logic signed [31:0]  current_ticks,
	input  logic [12:0]         max_speed,
	output swm_pkg::front_t     front_s1
);

	// one wrap step toward (-180, +180] degrees
	function automatic logic signed [17:0] wrap_step(input logic signed [17:0] d);
		logic signed [17:0] r;
		r = d;
		if (d > swm_pkg::HALF_TURN)
			r = 18'(d - swm_pkg::FULL_TURN);
		else if (d <= -swm_pkg::HALF_TURN)
			r = 18'(d + swm_pkg::FULL_TURN);
		return r;
	endfunction

	logic signed [17:0] d0;
	logic signed [17:0] d1;
	logic signed [17:0] d2;
	logic signed [15:0] delta;
	logic [14:0]        mag;
	logic               flip;
	logic signed [17:0] half;
	logic signed [15:0] rem;
	logic signed [14:0] spd;
	logic [13:0]        smag;
	swm_pkg::front_t    front;

	// raw error spans two turns at most, so two wrap steps suffice
	always_comb begin
		d0    = $signed({{2{target_angle[15]}}, target_angle})
		      - $signed({{2{current_angle[15]}}, current_angle});
		d1    = wrap_step(d0);
		d2    = wrap_step(d1);
		delta = d2[15:0];
		mag   = delta[15] ? 15'(-delta) : 15'(delta);
		flip  = mag > 15'(swm_pkg::FLIP_LIMIT);
	end

	// remaining error after a flip is the wrapped error turned by half a turn
	always_comb begin
		half = 18'(d2 + swm_pkg::HALF_TURN);
		if (half > swm_pkg::HALF_TURN)
			half = 18'(half - swm_pkg::FULL_TURN);
		rem = flip ? half[15:0] : delta;
	end

	// signed speed after a flip, split into magnitude and sign
	always_comb begin
		spd  = flip ? -$signed({target_speed[13], target_speed})
		            : $signed({target_speed[13], target_speed});
		smag = spd[14] ? 14'(-spd) : 14'(spd);
		front.smag  = smag;
		front.sneg  = spd[14];
		front.dead  = (18'(smag) * swm_pkg::DEADBAND_MUL) < 18'(max_speed);
		front.rmag  = rem[15] ? 15'(-rem) : 15'(rem);
		front.rneg  = rem[15];
		front.pos   = front.rmag > 15'(swm_pkg::MOVE_LIMIT);
		front.flip  = flip;
		front.ticks = current_ticks;
	end

	// stage register
	always_ff @(posedge clk) begin
		if (en) begin
			front_s1 <= front;
		end
	end

endmodule

// File: rtl/swm_drive.sv
// drive path: scale, inverse circumference, rounding and saturation
module swm_drive (
	input  logic               clk,
	input  logic               en,
	input  logic [13:0]        smag,
	input  logic               sneg,
	input  logic               dead,
	input  logic [8:0]         speed_scale,
	input  logic [21:0]        rev_per_meter,
	output logic signed [17:0] drive_rate_s5
);

	logic [22:0] mag_s2;
	logic        neg_s2;
	logic [44:0] mag_s3;
	logic        neg_s3;
	logic [16:0] q_s4;
	logic        neg_s4;
	logic [45:0] rnd;
	logic [21:0] rq;

	// round half away from zero on the magnitude, then clamp
	always_comb begin
		rnd = 46'(mag_s3) + swm_pkg::DRIVE_HALF;
		rq  = rnd[45:24];
	end

	// stages two to five
	always_ff @(posedge clk) begin
		if (en) begin
			mag_s2        <= dead ? 23'd0 : 23'(smag) * 23'(speed_scale);
			neg_s2        <= sneg;
			mag_s3        <= 45'(mag_s2) * 45'(rev_per_meter);
			neg_s3        <= neg_s2;
			q_s4          <= (rq > 22'(swm_pkg::DRIVE_MAX)) ? swm_pkg::DRIVE_MAX : rq[16:0];
			neg_s4        <= neg_s3;
			drive_rate_s5 <= neg_s4 ? -$signed({1'b0, q_s4}) : $signed({1'b0, q_s4});
		end
	end

endmodule

// File: rtl/swm_turn.sv
// turn path: error to ticks, divide by 25600, add to position, saturate
module swm_turn (
	input  logic               clk,
	input  logic               en,
	input  logic [14:0]        rmag,
	input  logic               rneg,
	input  logic               pos,
	input  logic signed [31:0] ticks,
	input  logic [15:0]        ticks_per_degree,
	output logic               turn_mode_s5,
	output logic signed [31:0] turn_target_s5
);

	logic [30:0]        tm_s2;
	logic               neg_s2;
	logic               pos_s2;
	logic signed [31:0] ticks_s2;
	logic [21:0]        u_s3;
	logic               neg_s3;
	logic               pos_s3;
	logic signed [31:0] ticks_s3;
	logic [17:0]        q_s4;
	logic               neg_s4;
	logic               pos_s4;
	logic signed [31:0] ticks_s4;
	logic [31:0]        biased;
	logic [44:0]        prod;
	logic signed [32:0] dt;
	logic signed [32:0] sum;
	logic signed [31:0] clamped;

	// add half the divisor, drop the power of two part
	assign biased = 32'(tm_s2) + swm_pkg::TURN_HALF;

	// reciprocal multiply is exact for a 22-bit dividend
	assign prod = 45'(u_s3) * swm_pkg::RECIP_25;

	// signed offset added to the position, clamped to 32 bits
	always_comb begin
		dt  = neg_s4 ? -$signed(33'(q_s4)) : $signed(33'(q_s4));
		sum = $signed({ticks_s4[31], ticks_s4}) + dt;
		if (sum[32] != sum[31])
			clamped = sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		else
			clamped = sum[31:0];
	end

	// stages two to five
	always_ff @(posedge clk) begin
		if (en) begin
			tm_s2          <= 31'(rmag) * 31'(ticks_per_degree);
			neg_s2         <= rneg;
			pos_s2         <= pos;
			ticks_s2       <= ticks;
			u_s3           <= biased[31:10];
			neg_s3         <= neg_s2;
			pos_s3         <= pos_s2;
			ticks_s3       <= ticks_s2;
			q_s4           <= prod[44:27];
			neg_s4         <= neg_s3;
			pos_s4         <= pos_s3;
			ticks_s4       <= ticks_s3;
			turn_mode_s5   <= pos_s4;
			turn_target_s5 <= pos_s4 ? clamped : 32'sd0;
		end
	end

endmodule

// File: rtl/swerve_module_setpoint.sv
// top level of the swerve module set-point block
//
// channel  direction  handshake                    payload
// s_axis   in         s_axis_tvalid/s_axis_tready  s_axis_tdata, 80 bits
// m_axis   out        m_axis_tvalid/m_axis_tready  m_axis_tdata, 56 bits
// cfg      in         cfg_valid/cfg_ready          cfg_index, cfg_data
//
// one item per cycle through five register stages while m_axis does not stall.
// reset clears the valid bits and loads the register defaults; cfg_ready is
// always high. a stall on m_axis freezes every stage at once, so s_axis_tready
// follows m_axis_tready whenever the output stage holds an item.
module swerve_module_setpoint (
	input  logic        clk,
	input  logic        arst_n,
	// target_speed[13:0], target_angle[29:14], current_angle[45:30],
	// current_ticks[77:46], zero fill [79:78]
	input  logic [79:0] s_axis_tdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// drive_rate[17:0], turn_mode[18], turn_target[50:19], wheel_flipped[51],
	// zero fill [55:52]
	output logic [55:0] m_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_index,
	input  logic [21:0] cfg_data
);

	swm_pkg::cfg_t      cfg;
	swm_pkg::front_t    front_s1;
	logic               en;
	logic [4:0]         v_q;
	logic               flip_s2;
	logic               flip_s3;
	logic               flip_s4;
	logic               flip_s5;
	logic signed [17:0] drive_rate_s5;
	logic               turn_mode_s5;
	logic signed [31:0] turn_target_s5;

	assign cfg_ready = 1'b1;

	// whole pipeline moves unless the output item is held
	assign en            = !v_q[4] || m_axis_tready;
	assign s_axis_tready = en;
	assign m_axis_tvalid = v_q[4];

	swm_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	swm_angle u_angle (
		.clk           (clk),
		.en            (en),
		.target_speed  ($signed(s_axis_tdata[13:0])),
		.target_angle  ($signed(s_axis_tdata[29:14])),
		.current_angle ($signed(s_axis_tdata[45:30])),
		.current_ticks ($signed(s_axis_tdata[77:46])),
		.max_speed     (cfg.max_speed),
		.front_s1      (front_s1)
	);

	swm_drive u_drive (
		.clk           (clk),
		.en            (en),
		.smag          (front_s1.smag),
		.sneg          (front_s1.sneg),
		.dead          (front_s1.dead),
		.speed_scale   (cfg.speed_scale),
		.rev_per_meter (cfg.rev_per_meter),
		.drive_rate_s5 (drive_rate_s5)
	);

	swm_turn u_turn (
		.clk              (clk),
		.en               (en),
		.rmag             (front_s1.rmag),
		.rneg             (front_s1.rneg),
		.pos              (front_s1.pos),
		.ticks            ($signed(front_s1.ticks)),
		.ticks_per_degree (cfg.ticks_per_degree),
		.turn_mode_s5     (turn_mode_s5),
		.turn_target_s5   (turn_target_s5)
	);

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 5'd0;
		end else if (en) begin
			v_q <= {v_q[3:0], s_axis_tvalid};
		end
	end

	// flip flag carried alongside the two paths
	always_ff @(posedge clk) begin
		if (en) begin
			flip_s2 <= front_s1.flip;
			flip_s3 <= flip_s2;
			flip_s4 <= flip_s3;
			flip_s5 <= flip_s4;
		end
	end

	// output item packing
	assign m_axis_tdata = {4'd0, flip_s5, turn_target_s5, turn_mode_s5, drive_rate_s5};

	// a stopped turn motor always gets a zero target
	a_stop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !turn_mode_s5 |-> turn_target_s5 == 32'sd0)
		else $error("turn target not zero in stop mode");

	// drive rate stays inside the symmetric clamp
	a_drive_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> drive_rate_s5 != -18'sd131072)
		else $error("drive rate outside clamp");

	// a stall keeps the first stage item in place
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_q[0] && !en |=> v_q[0] && $stable(front_s1))
		else $error("first stage item lost during stall");

	// an accepted item is in the first stage register in the next cycle
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> v_q[0])
		else $error("accepted item missing from first stage");

endmodule

// File: dv/setpoint_checker.sv
// checker for the swerve module set-point block: predicts each result and compares it
module setpoint_checker (
	input  logic        clk,
	input  logic        arst_n,
	// target_speed[13:0], target_angle[29:14], current_angle[45:30],
	// current_ticks[77:46], zero fill [79:78]
	input  logic [79:0] s_axis_tdata,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	// drive_rate[17:0], turn_mode[18], turn_target[50:19], wheel_flipped[51],
	// zero fill [55:52]
	input  logic [55:0] m_axis_tdata,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [3:0]  cfg_index,
	input  logic [21:0] cfg_data,
	output int          fail_count,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint DEADBAND_RATIO = 20;
	localparam longint RATE_LIMIT     = 131071;
	localparam longint RATE_DIV       = 16777216;
	localparam longint TURN_DIV       = 25600;
	localparam longint TICK_MAX       = 64'sd2147483647;
	localparam longint TICK_MIN       = -64'sd2147483648;

	typedef struct packed {
		logic [1:0]  fill;
		logic [31:0] current_ticks;
		logic [15:0] current_angle;
		logic [15:0] target_angle;
		logic [13:0] target_speed;
	} setpoint_in_t;

	typedef struct packed {
		logic [3:0]  fill;
		logic        wheel_flipped;
		logic [31:0] turn_target;
		logic        turn_mode;
		logic [17:0] drive_rate;
	} setpoint_out_t;

	// register mirror
	longint max_spd;
	longint spd_scale;
	longint rev_per_m;
	longint tpd_q8;

	setpoint_out_t wanted_q[$];

	function automatic longint magnitude(longint v);
		return (v < 0) ? -v : v;
	endfunction

	// angle error folded into (-180, +180] degrees
	function automatic longint wrap_angle(longint d);
		while (d <= -swm_pkg::HALF_TURN)
			d += swm_pkg::FULL_TURN;
		while (d > swm_pkg::HALF_TURN)
			d -= swm_pkg::FULL_TURN;
		return d;
	endfunction

	// nearest, ties away from zero
	function automatic longint round_div(longint num, longint den);
		if (num >= 0)
			return (num + den / 2) / den;
		return -((-num + den / 2) / den);
	endfunction

	function automatic longint clamp(longint v, longint lo, longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic setpoint_out_t predict_setpoint(setpoint_in_t it);
		longint speed, tgt, cur, ticks, err, rem, rate, target;
		logic flip, move;
		setpoint_out_t r;
		speed = longint'($signed(it.target_speed));
		tgt = longint'($signed(it.target_angle));
		cur = longint'($signed(it.current_angle));
		ticks = longint'($signed(it.current_ticks));
		err = wrap_angle(tgt - cur);
		flip = magnitude(err) > swm_pkg::FLIP_LIMIT;
		if (flip) begin
			speed = -speed;
			tgt += swm_pkg::HALF_TURN;
		end
		// drive path: deadband, then scale and divide by circumference
		rate = 0;
		if (magnitude(speed) * DEADBAND_RATIO >= max_spd)
			rate = clamp(round_div(speed * spd_scale * rev_per_m, RATE_DIV),
				-RATE_LIMIT, RATE_LIMIT);
		// turn path: position target only beyond one degree
		rem = wrap_angle(tgt - cur);
		move = magnitude(rem) > swm_pkg::MOVE_LIMIT;
		target = 0;
		if (move)
			target = clamp(ticks + round_div(rem * tpd_q8, TURN_DIV), TICK_MIN, TICK_MAX);
		r = '0;
		r.drive_rate = rate[17:0];
		r.turn_mode = move;
		r.turn_target = target[31:0];
		r.wheel_flipped = flip;
		return r;
	endfunction

	task automatic note_mismatch(string field, longint want, longint got);
		fail_count++;
		$display("%0t: %s expected %0d got %0d", $time, field, want, got);
	endtask

	// result compare, expectation capture and register mirror
	always @(posedge clk or negedge arst_n) begin
		setpoint_out_t got, want;
		if (!arst_n) begin
			wanted_q.delete();
			fail_count = 0;
			max_spd = swm_pkg::MAX_SPEED_RST;
			spd_scale = swm_pkg::SPEED_SCALE_RST;
			rev_per_m = swm_pkg::REV_PER_METER_RST;
			tpd_q8 = swm_pkg::TICKS_PER_DEGREE_RST;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata;
				if (wanted_q.size() == 0) begin
					fail_count++;
					$display("%0t: item with nothing expected, got %h", $time, m_axis_tdata);
				end else begin
					want = wanted_q.pop_front();
					if (got.drive_rate !== want.drive_rate)
						note_mismatch("drive_rate", $signed(want.drive_rate),
							$signed(got.drive_rate));
					if (got.turn_mode !== want.turn_mode)
						note_mismatch("turn_mode", want.turn_mode, got.turn_mode);
					if (got.turn_target !== want.turn_target)
						note_mismatch("turn_target", $signed(want.turn_target),
							$signed(got.turn_target));
					if (got.wheel_flipped !== want.wheel_flipped)
						note_mismatch("wheel_flipped", want.wheel_flipped, got.wheel_flipped);
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				wanted_q.push_back(predict_setpoint(s_axis_tdata));
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					swm_pkg::CFG_MAX_SPEED:        max_spd = cfg_data[12:0];
					swm_pkg::CFG_SPEED_SCALE:      spd_scale = cfg_data[8:0];
					swm_pkg::CFG_REV_PER_METER:    rev_per_m = cfg_data[21:0];
					swm_pkg::CFG_TICKS_PER_DEGREE: tpd_q8 = cfg_data[15:0];
					default: ;
				endcase
			end
		end
		pending = wanted_q.size();
	end

endmodule

// File: dv/tb_top.sv
// testbench top of the swerve module set-point block: stimulus, pacing and verdict
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [3:0] CFG_UNUSED = 4'd12;
	localparam int PHASES       = 6;
	localparam int PHASE_ITEMS  = 317;
	localparam int STALL_LIMIT  = 5000;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 20;
	localparam int EDGE_OFFSETS[9] = '{0, 100, 101, 9010, 9011, 17899, 17900, 17901, 18000};

	logic        clk;
	logic        arst_n;
	// target_speed[13:0], target_angle[29:14], current_angle[45:30],
	// current_ticks[77:46], zero fill [79:78]
	logic [79:0] s_axis_tdata;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	// drive_rate[17:0], turn_mode[18], turn_target[50:19], wheel_flipped[51],
	// zero fill [55:52]
	logic [55:0] m_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [3:0]  cfg_index;
	logic [21:0] cfg_data;

	int fail_count;
	int pending;
	int send_idle;
	int recv_idle;
	int hold_cycles;

	swerve_module_setpoint i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	setpoint_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// receiver: random stalls, plus a long hold-off on request
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				m_axis_tready <= 1'b0;
				hold_cycles--;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	// watchdog on cycles with no handshake at all
	initial begin
		int stall;
		stall = 0;
		while (stall < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready))
				stall = 0;
			else
				stall++;
		end
		$display("FAILURE");
		$finish;
	end

	// offer one item, with random gaps ahead of it; entered and left at a falling edge
	task automatic push_item(int speed, int tgt, int cur, int ticks);
		while ($urandom_range(99) < send_idle) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {2'b00, ticks[31:0], cur[15:0], tgt[15:0], speed[13:0]};
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	task automatic write_reg(logic [3:0] idx, logic [21:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	// new register set once the pipe has drained; unused upper bits get junk
	task automatic set_config(logic [12:0] ms, logic [8:0] sc, logic [21:0] rpm,
		logic [15:0] tpd);
		while (pending != 0)
			@(negedge clk);
		write_reg(swm_pkg::CFG_MAX_SPEED, {9'($urandom), ms});
		write_reg(swm_pkg::CFG_SPEED_SCALE, {13'($urandom), sc});
		write_reg(swm_pkg::CFG_REV_PER_METER, rpm);
		write_reg(swm_pkg::CFG_TICKS_PER_DEGREE, {6'($urandom), tpd});
		write_reg(CFG_UNUSED, 22'($urandom));
		cfg_valid <= 1'b0;
	endtask

	// random item biased toward the flip, move and saturation edges
	task automatic push_random_item();
		int speed, tgt, cur, ticks, off;
		if ($urandom_range(3) == 0)
			speed = $urandom_range(900) - 450;
		else
			speed = $urandom_range(16383) - 8192;
		if ($urandom_range(9) == 0)
			tgt = $urandom_range(65535) - 32768;
		else
			tgt = $urandom_range(36000) - 18000;
		case ($urandom_range(3))
			0: begin
				off = EDGE_OFFSETS[$urandom_range(8)];
				cur = $urandom_range(1) ? tgt - off : tgt + off;
			end
			1: cur = $urandom_range(65535) - 32768;
			default: cur = $urandom_range(36000) - 18000;
		endcase
		if ($urandom_range(7) == 0)
			ticks = $urandom_range(1) ? 32'h7fffffff - $urandom_range(100000)
				: 32'h80000000 + $urandom_range(100000);
		else
			ticks = $urandom;
		push_item(speed, tgt, cur, ticks);
	endtask

	// main stimulus
	initial begin
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = swm_pkg::CFG_MAX_SPEED;
		cfg_data = '0;
		send_idle = 7;
		recv_idle = 85;
		hold_cycles = 0;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int p = 0; p < PHASES; p++) begin
			if (p > 0) begin
				s_axis_tvalid <= 1'b0;
				case (p)
					1: set_config(13'd8191, 9'd511, 22'h3fffff, 16'hffff);
					2: set_config(13'd0, 9'd0, 22'd0, 16'd0);
					3: set_config(13'd1, 9'd256, 22'h3fffff, 16'd0);
					4: set_config(13'($urandom), 9'($urandom_range(256)), 22'($urandom),
						16'($urandom));
					default: set_config(swm_pkg::MAX_SPEED_RST, swm_pkg::SPEED_SCALE_RST,
						swm_pkg::REV_PER_METER_RST, swm_pkg::TICKS_PER_DEGREE_RST);
				endcase
			end
			// receiver sparse first, then sender sparse, then full rate
			if (p < 2) begin
				send_idle = 7;
				recv_idle = 85;
			end else if (p < 4) begin
				send_idle = 85;
				recv_idle = 7;
			end else begin
				send_idle = 0;
				recv_idle = 0;
			end
			if (p == 0) begin
				// speed extremes and the deadband edge
				push_item(8191, 0, 0, 0);
				push_item(-8191, 0, 0, 0);
				push_item(-8192, 1000, 0, 1000);
				push_item(49, 0, 0, 0);
				push_item(50, 0, 0, 0);
				push_item(-50, 0, 0, 0);
				// flip threshold and exact half turn both ways
				push_item(0, 9010, 0, 0);
				push_item(1000, 9011, 0, 0);
				push_item(1000, -9011, 0, 0);
				push_item(500, 18000, 0, 0);
				push_item(500, -18000, 0, 0);
				// one degree move threshold
				push_item(500, 100, 0, 0);
				push_item(500, 101, 0, 0);
				push_item(500, -101, 0, -100);
				// angles beyond a half turn
				push_item(8191, 32767, -32768, 0);
				push_item(-8192, -32768, 32767, 32'h7fffffff);
				// tick saturation at the low end, and ticks near both limits
				push_item(300, 17000, 0, 32'h7fffffff);
				push_item(300, -5000, 0, 32'h80000000);
				push_item(300, 5000, 0, 32'h80000000);
				push_item(0, 0, 0, 0);
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// long receiver hold-off while items keep coming
				if (p == PHASES - 1 && n == 100)
					hold_cycles = HOLD_CYCLES;
				push_random_item();
			end
		end

		s_axis_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// File: sim.f
rtl/swm_pkg.sv
rtl/swm_cfg.sv
rtl/swm_angle.sv
rtl/swm_drive.sv
rtl/swm_turn.sv
rtl/swerve_module_setpoint.sv
dv/setpoint_checker.sv
dv/tb_top.sv
